### design/wlat_pkg.sv
package wlat_pkg;

  // Default sizes of the table.
  localparam int DEF_NODES        = 16;
  localparam int DEF_WAVELENGTHS  = 16;
  localparam int DEF_CONN_ID_BITS = 10;

  // Fixed widths of the port fields.
  localparam int CMD_W     = 3;
  localparam int NODE_W    = 4;
  localparam int WL_W      = 4;
  localparam int ID_W      = 10;
  localparam int CNT_OUT_W = 5;

  // Command codes. The remaining codes of the field are unused.
  typedef enum logic [CMD_W-1:0] {
    CMD_CHECK   = 3'd0,
    CMD_ALLOC   = 3'd1,
    CMD_RELEASE = 3'd2,
    CMD_QUERY   = 3'd3,
    CMD_CLEAR   = 3'd4
  } cmd_t;

  typedef enum logic [2:0] {
    S_SWEEP_INIT,
    S_IDLE,
    S_RD_FWD,
    S_USE_FWD,
    S_RD_REV,
    S_USE_REV,
    S_SWEEP_CLR,
    S_DONE
  } state_t;

  // Controller to datapath.
  typedef struct packed {
    logic take;
    logic sweep;
    logic sel_rev;
    logic use_data;
    logic load_out;
  } ctl_t;

  // Datapath to controller.
  typedef struct packed {
    logic [CMD_W-1:0] cmd;
    logic             bidir;
    logic             act_ok;
    logic             out_free;
    logic             sweep_last;
  } sts_t;

endpackage

### design/wlat_ram.sv
module wlat_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### design/wlat_ctrl.sv
module wlat_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_stall,
  input  wlat_pkg::sts_t  sts,
  output wlat_pkg::ctl_t  ctl
);

  wlat_pkg::state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= wlat_pkg::S_SWEEP_INIT;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next   = state;
    ctl          = '0;
    in_stall     = 1'b1;
    unique case (state)
      wlat_pkg::S_SWEEP_INIT: begin
        ctl.sweep = 1'b1;
        if (sts.sweep_last) begin
          state_next = wlat_pkg::S_IDLE;
        end
      end
      wlat_pkg::S_IDLE: begin
        in_stall = 1'b0;
        ctl.take = in_valid;
        if (in_valid) begin
          state_next = wlat_pkg::S_RD_FWD;
        end
      end
      wlat_pkg::S_RD_FWD: begin
        if (sts.cmd == wlat_pkg::CMD_CLEAR) begin
          state_next = wlat_pkg::S_SWEEP_CLR;
        end else if (sts.cmd == wlat_pkg::CMD_CHECK || sts.cmd == wlat_pkg::CMD_QUERY) begin
          state_next = wlat_pkg::S_USE_FWD;
        end else if ((sts.cmd == wlat_pkg::CMD_ALLOC || sts.cmd == wlat_pkg::CMD_RELEASE)
                     && sts.act_ok) begin
          state_next = wlat_pkg::S_USE_FWD;
        end else begin
          state_next = wlat_pkg::S_DONE;
        end
      end
      wlat_pkg::S_USE_FWD: begin
        ctl.use_data = 1'b1;
        if (sts.bidir && sts.cmd != wlat_pkg::CMD_QUERY) begin
          state_next = wlat_pkg::S_RD_REV;
        end else begin
          state_next = wlat_pkg::S_DONE;
        end
      end
      wlat_pkg::S_RD_REV: begin
        ctl.sel_rev = 1'b1;
        state_next  = wlat_pkg::S_USE_REV;
      end
      wlat_pkg::S_USE_REV: begin
        ctl.sel_rev  = 1'b1;
        ctl.use_data = 1'b1;
        state_next   = wlat_pkg::S_DONE;
      end
      wlat_pkg::S_SWEEP_CLR: begin
        ctl.sweep = 1'b1;
        if (sts.sweep_last) begin
          state_next = wlat_pkg::S_DONE;
        end
      end
      wlat_pkg::S_DONE: begin
        if (sts.out_free) begin
          ctl.load_out = 1'b1;
          state_next   = wlat_pkg::S_IDLE;
        end
      end
      default: begin
        state_next = wlat_pkg::S_IDLE;
      end
    endcase
  end

endmodule

### design/wlat_dpath.sv
module wlat_dpath #(
  parameter int NODES        = wlat_pkg::DEF_NODES,
  parameter int WAVELENGTHS  = wlat_pkg::DEF_WAVELENGTHS,
  parameter int CONN_ID_BITS = wlat_pkg::DEF_CONN_ID_BITS
) (
  input  logic                          clk,
  input  logic                          rst,
  input  wlat_pkg::ctl_t                ctl,
  output wlat_pkg::sts_t                sts,
  input  logic [wlat_pkg::CMD_W-1:0]    command,
  input  logic [wlat_pkg::NODE_W-1:0]   from_node,
  input  logic [wlat_pkg::NODE_W-1:0]   to_node,
  input  logic [wlat_pkg::WL_W-1:0]     wavelength,
  input  logic                          bidirectional,
  input  logic [wlat_pkg::ID_W-1:0]     conn_id,
  input  logic                          last_hop,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic                          path_free,
  output logic [wlat_pkg::ID_W-1:0]     owner_id,
  output logic [wlat_pkg::CNT_OUT_W-1:0] used_count,
  output logic [wlat_pkg::CNT_OUT_W-1:0] free_count,
  output logic                          path_end
);

  localparam int NB     = $clog2(NODES);
  localparam int WB     = (WAVELENGTHS > 1) ? $clog2(WAVELENGTHS) : 1;
  localparam int LAW    = 2 * NB;
  localparam int OAW    = WB + LAW;
  localparam int CW     = $clog2(WAVELENGTHS + 1);
  localparam int IDO_W  = wlat_pkg::ID_W;
  localparam int CNTO_W = wlat_pkg::CNT_OUT_W;

  // Latched item.
  logic [wlat_pkg::CMD_W-1:0]  cmd_r;
  logic [wlat_pkg::NODE_W-1:0] from_r;
  logic [wlat_pkg::NODE_W-1:0] to_r;
  logic [wlat_pkg::WL_W-1:0]   wl_r;
  logic                        bidir_r;
  logic [CONN_ID_BITS-1:0]     id_r;
  logic                        last_r;

  logic                        busy;
  logic                        acc;
  logic [OAW-1:0]              sw_cnt;
  logic [IDO_W-1:0]            res_owner;
  logic [CNTO_W-1:0]           res_used;
  logic [CNTO_W-1:0]           res_free;

  logic                        nodes_ok;
  logic                        wl_ok;
  logic [NB-1:0]               a_i;
  logic [NB-1:0]               b_i;
  logic [LAW-1:0]              link;
  logic [OAW-1:0]              own_addr;
  logic                        is_alloc;
  logic                        is_rel;
  logic                        do_write;

  logic                        own_we;
  logic [OAW-1:0]              own_waddr;
  logic [CONN_ID_BITS-1:0]     own_wdata;
  logic [CONN_ID_BITS-1:0]     own_rd;
  logic                        cnt_we;
  logic [LAW-1:0]              cnt_waddr;
  logic [CW-1:0]               cnt_wdata;
  logic [CW-1:0]               cnt_rd;
  logic [CW-1:0]               cnt_upd;
  logic                        acc_hop;

  assign nodes_ok = (32'(from_r) < NODES) && (32'(to_r) < NODES);
  assign wl_ok    = 32'(wl_r) < WAVELENGTHS;
  assign a_i      = NB'(from_r);
  assign b_i      = NB'(to_r);
  assign link     = ctl.sel_rev ? {b_i, a_i} : {a_i, b_i};
  assign own_addr = {WB'(wl_r), link};
  assign is_alloc = cmd_r == wlat_pkg::CMD_ALLOC;
  assign is_rel   = cmd_r == wlat_pkg::CMD_RELEASE;
  assign do_write = ctl.use_data && (is_alloc || is_rel);

  always_comb begin
    cnt_upd = cnt_rd;
    if (is_alloc && (32'(cnt_rd) < WAVELENGTHS)) begin
      cnt_upd = cnt_rd + CW'(1);
    end else if (is_rel && cnt_rd != '0) begin
      cnt_upd = cnt_rd - CW'(1);
    end
  end

  assign own_we    = ctl.sweep || do_write;
  assign own_waddr = ctl.sweep ? sw_cnt : own_addr;
  assign own_wdata = (!ctl.sweep && is_alloc) ? id_r : '0;
  assign cnt_we    = ctl.sweep || do_write;
  assign cnt_waddr = ctl.sweep ? sw_cnt[LAW-1:0] : link;
  assign cnt_wdata = ctl.sweep ? '0 : cnt_upd;

  wlat_ram #(
    .WIDTH (CONN_ID_BITS),
    .DEPTH (2 ** OAW)
  ) u_owner_ram (
    .clk   (clk),
    .we    (own_we),
    .waddr (own_waddr),
    .wdata (own_wdata),
    .raddr (own_addr),
    .rdata (own_rd)
  );

  wlat_ram #(
    .WIDTH (CW),
    .DEPTH (2 ** LAW)
  ) u_count_ram (
    .clk   (clk),
    .we    (cnt_we),
    .waddr (cnt_waddr),
    .wdata (cnt_wdata),
    .raddr (link),
    .rdata (cnt_rd)
  );

  assign sts.cmd        = cmd_r;
  assign sts.bidir      = bidir_r;
  assign sts.act_ok     = nodes_ok && wl_ok && (!is_alloc || id_r != '0);
  assign sts.out_free   = !out_valid || !out_stall;
  assign sts.sweep_last = &sw_cnt;

  assign acc_hop = acc && !busy;

  always_ff @(posedge clk) begin
    if (ctl.take) begin
      cmd_r     <= command;
      from_r    <= from_node;
      to_r      <= to_node;
      wl_r      <= wavelength;
      bidir_r   <= bidirectional;
      id_r      <= CONN_ID_BITS'(conn_id);
      last_r    <= last_hop;
      busy      <= 1'b0;
      res_owner <= '0;
      res_used  <= '0;
      res_free  <= '0;
    end else if (ctl.use_data) begin
      if (cmd_r == wlat_pkg::CMD_CHECK) begin
        busy <= busy || !(nodes_ok && wl_ok) || own_rd != '0;
      end
      if (cmd_r == wlat_pkg::CMD_QUERY && nodes_ok) begin
        res_owner <= wl_ok ? IDO_W'(own_rd) : '0;
        res_used  <= CNTO_W'(cnt_rd);
        res_free  <= CNTO_W'(WAVELENGTHS - 32'(cnt_rd));
      end
    end
    if (ctl.load_out) begin
      path_free  <= (cmd_r == wlat_pkg::CMD_CHECK) && last_r && acc_hop;
      owner_id   <= res_owner;
      used_count <= res_used;
      free_count <= res_free;
      path_end   <= last_r;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      acc       <= 1'b1;
      sw_cnt    <= '0;
      out_valid <= 1'b0;
    end else begin
      if (ctl.sweep) begin
        sw_cnt <= sw_cnt + OAW'(1);
        acc    <= 1'b1;
      end else if (ctl.load_out && cmd_r == wlat_pkg::CMD_CHECK) begin
        acc <= last_r ? 1'b1 : acc_hop;
      end
      if (ctl.load_out) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

### design/wavelength_link_allocation_table.sv
// Wavelength link allocation table.
// Input channel (in_valid / in_stall) carries one hop, query or clear per
// transfer; output channel (out_valid / out_stall) returns exactly one result
// transfer for every input transfer, in order.
// The block handles one item at a time. Each link that an item touches needs
// a memory read and then a step that uses the read data: a query, a check,
// and an allocate or release without the reverse link use the forward link
// only, and a bidirectional check, allocate or release uses both links. An
// unused command, an allocate or release dropped for a bad field, and an
// allocate with a zero connection id skip the step that uses the data. The
// result then goes to the output register, and the next item is accepted
// once the controller is back in its idle state. Clear walks the owner memory
// one entry a cycle, through all 2**(address bits) entries (4096 at the
// default sizes), before its result goes to the output register.
// After reset the same clearing pass runs, and in_stall stays high until it
// completes. The result sits in an output register: while the receiver
// stalls, the next item may still be accepted and worked on; it then waits
// in its final state until the register is taken.
module wavelength_link_allocation_table #(
  parameter int NODES        = wlat_pkg::DEF_NODES,
  parameter int WAVELENGTHS  = wlat_pkg::DEF_WAVELENGTHS,
  parameter int CONN_ID_BITS = wlat_pkg::DEF_CONN_ID_BITS
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [wlat_pkg::CMD_W-1:0]     command,
  input  logic [wlat_pkg::NODE_W-1:0]    from_node,
  input  logic [wlat_pkg::NODE_W-1:0]    to_node,
  input  logic [wlat_pkg::WL_W-1:0]      wavelength,
  input  logic                           bidirectional,
  input  logic [wlat_pkg::ID_W-1:0]      conn_id,
  input  logic                           last_hop,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic                           path_free,
  output logic [wlat_pkg::ID_W-1:0]      owner_id,
  output logic [wlat_pkg::CNT_OUT_W-1:0] used_count,
  output logic [wlat_pkg::CNT_OUT_W-1:0] free_count,
  output logic                           path_end
);

  // The controller sequences each item; the datapath holds the latched item,
  // both memories, the check flag and the output register.
  wlat_pkg::ctl_t ctl;
  wlat_pkg::sts_t sts;

  wlat_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .ctl      (ctl)
  );

  wlat_dpath #(
    .NODES        (NODES),
    .WAVELENGTHS  (WAVELENGTHS),
    .CONN_ID_BITS (CONN_ID_BITS)
  ) u_dpath (
    .clk           (clk),
    .rst           (rst),
    .ctl           (ctl),
    .sts           (sts),
    .command       (command),
    .from_node     (from_node),
    .to_node       (to_node),
    .wavelength    (wavelength),
    .bidirectional (bidirectional),
    .conn_id       (conn_id),
    .last_hop      (last_hop),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .path_free     (path_free),
    .owner_id      (owner_id),
    .used_count    (used_count),
    .free_count    (free_count),
    .path_end      (path_end)
  );

endmodule

### tb/tb.sv
`timescale 1ns / 1ps

// Testbench for the wavelength link allocation table.
//
// The testbench keeps its own copy of the owner table, the per-link use
// counts and the running path check flag. It updates that copy for every
// input transfer and derives the one result that the transfer must produce.
// A checker process compares every output transfer with the oldest
// prediction, field by field.
//
// Test flow:
//   - a directed pass over the corner cases: the reverse-link busy rule for
//     bidirectional checks, an allocate with connection id zero, releasing
//     a free entry, a loop link (from == to), unused command codes, and a
//     clear;
//   - count saturation at both ends, on a loop link;
//   - random traffic built mostly from well formed paths: check a path,
//     allocate it if it is free, then later release it, with queries and
//     noise items mixed in;
//   - a long hold-off on the output while items keep arriving, so that the
//     block fills and stalls its input.
// The idle rates of the sender and the receiver change between phases.
module tb;

  localparam int NODES       = wlat_pkg::DEF_NODES;
  localparam int WAVELENGTHS = wlat_pkg::DEF_WAVELENGTHS;

  // Command codes that the block leaves unused.
  localparam logic [wlat_pkg::CMD_W-1:0] CMD_SPARE_A = 3'd5;
  localparam logic [wlat_pkg::CMD_W-1:0] CMD_SPARE_B = 3'd6;
  localparam logic [wlat_pkg::CMD_W-1:0] CMD_SPARE_C = 3'd7;

  // Length of the deliberate output hold-off, and the quiet time at the end.
  localparam int HOLD_CYCLES = 150;
  localparam int TAIL_CYCLES = 24;

  // One hop, query or clear, as it appears on the input channel.
  typedef struct packed {
    logic [wlat_pkg::CMD_W-1:0]  cmd;
    logic [wlat_pkg::NODE_W-1:0] from;
    logic [wlat_pkg::NODE_W-1:0] to;
    logic [wlat_pkg::WL_W-1:0]   wl;
    logic                        bidir;
    logic [wlat_pkg::ID_W-1:0]   id;
    logic                        last;
  } hop_t;

  // One result, as it appears on the output channel.
  typedef struct packed {
    logic                           path_free;
    logic [wlat_pkg::ID_W-1:0]      owner;
    logic [wlat_pkg::CNT_OUT_W-1:0] used;
    logic [wlat_pkg::CNT_OUT_W-1:0] avail;
    logic                           path_end;
  } reading_t;

  // A path of up to four hops on one wavelength, node[0] -> ... -> node[hops].
  typedef struct packed {
    logic [4:0][wlat_pkg::NODE_W-1:0] node;
    logic [2:0]                       hops;
    logic [wlat_pkg::WL_W-1:0]        wl;
    logic                             bidir;
    logic [wlat_pkg::ID_W-1:0]        id;
  } route_t;

  logic                           clk = 1'b0;
  logic                           rst = 1'b1;
  logic                           in_valid = 1'b0;
  logic                           in_stall;
  logic [wlat_pkg::CMD_W-1:0]     command = '0;
  logic [wlat_pkg::NODE_W-1:0]    from_node = '0;
  logic [wlat_pkg::NODE_W-1:0]    to_node = '0;
  logic [wlat_pkg::WL_W-1:0]      wavelength = '0;
  logic                           bidirectional = 1'b0;
  logic [wlat_pkg::ID_W-1:0]      conn_id = '0;
  logic                           last_hop = 1'b0;
  logic                           out_valid;
  logic                           out_stall = 1'b0;
  logic                           path_free;
  logic [wlat_pkg::ID_W-1:0]      owner_id;
  logic [wlat_pkg::CNT_OUT_W-1:0] used_count;
  logic [wlat_pkg::CNT_OUT_W-1:0] free_count;
  logic                           path_end;

  // Mirror of the block's state.
  logic [wlat_pkg::ID_W-1:0]      owner_mirror [NODES][NODES][WAVELENGTHS];
  logic [wlat_pkg::CNT_OUT_W-1:0] link_load [NODES][NODES];
  logic                           path_ok;

  // Results that the block still owes, oldest first.
  reading_t awaited_results [$];
  // Paths currently believed to be allocated, candidates for release.
  route_t   routes_held [$];

  // Idle rates in percent, changed by the test sequence.
  int send_gap_pct   = 0;
  int recv_stall_pct = 0;

  // The test sequence bumps holds_asked; the receiver serves each request once.
  int holds_asked = 0;
  int holds_taken = 0;
  int hold_left   = 0;

  int failures          = 0;
  int items_sent        = 0;
  int results_checked   = 0;
  int routes_allocated  = 0;
  int clears_seen       = 0;

  wavelength_link_allocation_table uut (.*);

  initial begin
    forever #4 clk = ~clk;
  end

  // Wipes the mirrored owner table and use counts.
  function automatic void wipe_mirror();
    for (int a = 0; a < NODES; a++) begin
      for (int b = 0; b < NODES; b++) begin
        link_load[a][b] = '0;
        for (int w = 0; w < WAVELENGTHS; w++) owner_mirror[a][b][w] = '0;
      end
    end
  endfunction

  // Applies one accepted transfer to the mirror and returns the result that
  // the block has to give for it.
  function automatic reading_t apply_to_mirror(input hop_t it);
    reading_t                    r;
    logic                        nodes_ok;
    logic                        wl_ok;
    logic                        hop_busy;
    logic [wlat_pkg::NODE_W-1:0] x;
    logic [wlat_pkg::NODE_W-1:0] y;
    r = '0;
    nodes_ok = (it.from < NODES) && (it.to < NODES);
    wl_ok = it.wl < WAVELENGTHS;
    case (it.cmd) inside
      wlat_pkg::CMD_CHECK: begin
        // Out-of-range hops count as busy. With bidirectional set, a busy
        // reverse link blocks the hop just as the forward one does.
        hop_busy = 1'b1;
        if (nodes_ok && wl_ok) begin
          hop_busy = (owner_mirror[it.from][it.to][it.wl] != '0) ||
                     (it.bidir && owner_mirror[it.to][it.from][it.wl] != '0);
        end
        if (hop_busy) path_ok = 1'b0;
        if (it.last) begin
          r.path_free = path_ok;
          path_ok = 1'b1;
        end
      end
      wlat_pkg::CMD_ALLOC, wlat_pkg::CMD_RELEASE: begin
        // Connection id zero makes an allocate a no-op. A loop link with
        // bidirectional set is written twice, so its count moves by two.
        if (nodes_ok && wl_ok && (it.cmd == wlat_pkg::CMD_RELEASE || it.id != '0)) begin
          for (int d = 0; d < (it.bidir ? 2 : 1); d++) begin
            x = (d == 0) ? it.from : it.to;
            y = (d == 0) ? it.to : it.from;
            if (it.cmd == wlat_pkg::CMD_ALLOC) begin
              owner_mirror[x][y][it.wl] = it.id;
              if (link_load[x][y] < WAVELENGTHS) link_load[x][y]++;
            end else begin
              owner_mirror[x][y][it.wl] = '0;
              if (link_load[x][y] > 0) link_load[x][y]--;
            end
          end
        end
      end
      wlat_pkg::CMD_QUERY: begin
        if (nodes_ok) begin
          if (wl_ok) r.owner = owner_mirror[it.from][it.to][it.wl];
          r.used = link_load[it.from][it.to];
          r.avail = wlat_pkg::CNT_OUT_W'(WAVELENGTHS - int'(link_load[it.from][it.to]));
        end
      end
      wlat_pkg::CMD_CLEAR: begin
        wipe_mirror();
        path_ok = 1'b1;
        clears_seen++;
      end
      default: ;
    endcase
    r.path_end = it.last;
    return r;
  endfunction

  function automatic hop_t make_hop(input logic [wlat_pkg::CMD_W-1:0] c, input int a,
                                    input int b, input int w, input int bd, input int id,
                                    input int lst);
    hop_t h;
    h.cmd   = c;
    h.from  = a[wlat_pkg::NODE_W-1:0];
    h.to    = b[wlat_pkg::NODE_W-1:0];
    h.wl    = w[wlat_pkg::WL_W-1:0];
    h.bidir = bd[0];
    h.id    = id[wlat_pkg::ID_W-1:0];
    h.last  = lst[0];
    return h;
  endfunction

  // Most nodes come from a small cluster so that links collide and fill up.
  function automatic int pick_node();
    if ($urandom_range(0, 99) < 70) return $urandom_range(0, 5);
    return $urandom_range(0, NODES - 1);
  endfunction

  // Offers one item, with a random gap in front, and waits for its transfer.
  // in_valid stays high afterward so that back-to-back items need no gap;
  // wait_idle() lowers it.
  task automatic send_item(input hop_t it);
    while ($urandom_range(0, 99) < send_gap_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid      <= 1'b1;
    command       <= it.cmd;
    from_node     <= it.from;
    to_node       <= it.to;
    wavelength    <= it.wl;
    bidirectional <= it.bidir;
    conn_id       <= it.id;
    last_hop      <= it.last;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    awaited_results.push_back(apply_to_mirror(it));
    items_sent++;
  endtask

  // Sends every hop of a path with one command, marking the final hop.
  task automatic run_route(input route_t rt, input logic [wlat_pkg::CMD_W-1:0] c);
    for (int h = 0; h < rt.hops; h++) begin
      send_item(make_hop(c, rt.node[h], rt.node[h+1], rt.wl, rt.bidir, rt.id,
                         h == rt.hops - 1));
    end
  endtask

  // Stops offering and waits until every owed result has come back.
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (awaited_results.size() != 0) @(posedge clk);
  endtask

  task automatic test_directed();
    // Empty table: a query shows all wavelengths free, a lone check is free.
    send_item(make_hop(wlat_pkg::CMD_QUERY, 0, 0, 0, 0, 1, 1));
    send_item(make_hop(wlat_pkg::CMD_CHECK, 0, 1, 0, 0, 1, 1));
    // Allocate one direction with the largest id, then check both ways.
    send_item(make_hop(wlat_pkg::CMD_ALLOC, 3, 5, 7, 0, 1023, 1));
    send_item(make_hop(wlat_pkg::CMD_CHECK, 3, 5, 7, 0, 1, 1));
    // The reverse direction is busy only when bidirectional is asked for.
    send_item(make_hop(wlat_pkg::CMD_CHECK, 5, 3, 7, 1, 1, 1));
    send_item(make_hop(wlat_pkg::CMD_CHECK, 5, 3, 7, 0, 1, 1));
    // An allocate with connection id zero must leave the table alone.
    send_item(make_hop(wlat_pkg::CMD_ALLOC, 1, 2, 15, 0, 0, 1));
    send_item(make_hop(wlat_pkg::CMD_QUERY, 1, 2, 15, 0, 1, 1));
    // Bidirectional allocate at the top node and wavelength, smallest id.
    send_item(make_hop(wlat_pkg::CMD_ALLOC, 15, 0, 15, 1, 1, 1));
    send_item(make_hop(wlat_pkg::CMD_QUERY, 0, 15, 15, 0, 1, 1));
    // Three-hop check with a busy middle hop, then a free two-hop path.
    send_item(make_hop(wlat_pkg::CMD_CHECK, 4, 6, 2, 0, 1, 0));
    send_item(make_hop(wlat_pkg::CMD_CHECK, 15, 0, 15, 0, 1, 0));
    send_item(make_hop(wlat_pkg::CMD_CHECK, 6, 8, 2, 0, 1, 1));
    send_item(make_hop(wlat_pkg::CMD_CHECK, 4, 6, 2, 0, 1, 0));
    send_item(make_hop(wlat_pkg::CMD_CHECK, 6, 8, 2, 0, 1, 1));
    // Releasing a free entry keeps the count at zero.
    send_item(make_hop(wlat_pkg::CMD_RELEASE, 2, 2, 0, 0, 1, 1));
    send_item(make_hop(wlat_pkg::CMD_QUERY, 2, 2, 0, 0, 1, 1));
    send_item(make_hop(wlat_pkg::CMD_RELEASE, 3, 5, 7, 0, 1, 1));
    send_item(make_hop(wlat_pkg::CMD_QUERY, 3, 5, 7, 0, 1, 1));
    // A loop link written both ways counts twice.
    send_item(make_hop(wlat_pkg::CMD_ALLOC, 9, 9, 3, 1, 512, 1));
    send_item(make_hop(wlat_pkg::CMD_QUERY, 9, 9, 3, 0, 1, 1));
    // Unused command codes, with the other fields at their extremes.
    send_item(make_hop(CMD_SPARE_A, 15, 15, 15, 1, 1023, 1));
    send_item(make_hop(CMD_SPARE_B, 0, 0, 0, 0, 0, 0));
    send_item(make_hop(CMD_SPARE_C, 15, 15, 15, 1, 1023, 1));
    // Clear, then the old allocation must be gone.
    send_item(make_hop(wlat_pkg::CMD_CLEAR, 0, 0, 0, 0, 1, 1));
    send_item(make_hop(wlat_pkg::CMD_QUERY, 15, 0, 15, 0, 1, 1));
    send_item(make_hop(wlat_pkg::CMD_CHECK, 15, 0, 15, 1, 1, 1));
    wait_idle();
  endtask

  // Drives the use count of a loop link past both limits. Each bidirectional
  // transfer on a loop link moves the count by two.
  task automatic test_count_limits();
    for (int w = 0; w < 9; w++) begin
      send_item(make_hop(wlat_pkg::CMD_ALLOC, 10, 10, w, 1, w + 1, 1));
    end
    send_item(make_hop(wlat_pkg::CMD_QUERY, 10, 10, 0, 0, 1, 1));
    send_item(make_hop(wlat_pkg::CMD_ALLOC, 10, 10, 15, 0, 77, 1));
    send_item(make_hop(wlat_pkg::CMD_QUERY, 10, 10, 15, 0, 1, 1));
    for (int w = 0; w < 9; w++) begin
      send_item(make_hop(wlat_pkg::CMD_RELEASE, 10, 10, w, 1, 1, 1));
    end
    send_item(make_hop(wlat_pkg::CMD_QUERY, 10, 10, 15, 0, 1, 1));
    wait_idle();
  endtask

  // Random traffic, mostly complete path setups and teardowns.
  task automatic test_random_traffic(input int count);
    route_t                     rt;
    int                         target;
    int                         pick;
    int                         k;
    logic                       busy;
    logic [wlat_pkg::CMD_W-1:0] c;
    target = items_sent + count;
    while (items_sent < target) begin
      pick = $urandom_range(0, 99);
      if (pick < 45) begin
        // Check a fresh path; allocate it when free, and now and then anyway
        // so that owners get overwritten and counts climb.
        rt.hops  = 3'($urandom_range(1, 4));
        rt.wl    = wlat_pkg::WL_W'($urandom_range(0, WAVELENGTHS - 1));
        rt.bidir = 1'($urandom_range(0, 1));
        rt.id    = wlat_pkg::ID_W'($urandom_range(1, 1023));
        for (int n = 0; n < 5; n++) rt.node[n] = wlat_pkg::NODE_W'(pick_node());
        run_route(rt, wlat_pkg::CMD_CHECK);
        busy = 1'b0;
        for (int h = 0; h < rt.hops; h++) begin
          if (owner_mirror[rt.node[h]][rt.node[h+1]][rt.wl] != '0 ||
              (rt.bidir && owner_mirror[rt.node[h+1]][rt.node[h]][rt.wl] != '0))
            busy = 1'b1;
        end
        if (!busy || $urandom_range(0, 9) == 0) begin
          run_route(rt, wlat_pkg::CMD_ALLOC);
          routes_held.push_back(rt);
          routes_allocated++;
        end
      end else if (pick < 60 && routes_held.size() != 0) begin
        k = $urandom_range(0, routes_held.size() - 1);
        run_route(routes_held[k], wlat_pkg::CMD_RELEASE);
        routes_held.delete(k);
      end else if (pick < 85) begin
        send_item(make_hop(wlat_pkg::CMD_QUERY, pick_node(), pick_node(),
                           $urandom_range(0, WAVELENGTHS - 1), $urandom_range(0, 1),
                           $urandom_range(0, 1023), $urandom_range(0, 1)));
      end else begin
        // Noise: any command, any field values. A clear walks the whole
        // table, so most of the clears drawn here are turned into queries.
        c = wlat_pkg::CMD_W'($urandom_range(0, 7));
        if (c == wlat_pkg::CMD_CLEAR && $urandom_range(0, 9) != 0) c = wlat_pkg::CMD_QUERY;
        send_item(make_hop(c, $urandom_range(0, 15), $urandom_range(0, 15),
                           $urandom_range(0, 15), $urandom_range(0, 1),
                           $urandom_range(0, 1023), $urandom_range(0, 1)));
      end
    end
    wait_idle();
  endtask

  // The receiver stops taking results for a long stretch while the sender
  // keeps offering, so the output register fills and in_stall must rise.
  task automatic test_output_backpressure();
    holds_asked++;
    for (int i = 0; i < 12; i++) begin
      send_item(make_hop((i % 2 == 0) ? wlat_pkg::CMD_ALLOC : wlat_pkg::CMD_QUERY,
                         pick_node(), pick_node(),
                         $urandom_range(0, WAVELENGTHS - 1), $urandom_range(0, 1),
                         $urandom_range(1, 1023), 1));
    end
    wait_idle();
  endtask

  // Receiver: random stalls, plus the long hold-off when one is requested.
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (holds_taken != holds_asked) begin
      holds_taken <= holds_asked;
      hold_left   <= HOLD_CYCLES;
      out_stall   <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
    end
  end

  // Checker: every output transfer against the oldest prediction.
  always @(posedge clk) begin : check_results
    reading_t want;
    if (!rst && out_valid && !out_stall) begin
      if (awaited_results.size() == 0) begin
        $error("result transfer with no prediction waiting");
        failures++;
      end else begin
        want = awaited_results.pop_front();
        results_checked++;
        if (path_free !== want.path_free) begin
          $error("path_free: expected %0d, actual %0d", want.path_free, path_free);
          failures++;
        end
        if (owner_id !== want.owner) begin
          $error("owner_id: expected %0d, actual %0d", want.owner, owner_id);
          failures++;
        end
        if (used_count !== want.used) begin
          $error("used_count: expected %0d, actual %0d", want.used, used_count);
          failures++;
        end
        if (free_count !== want.avail) begin
          $error("free_count: expected %0d, actual %0d", want.avail, free_count);
          failures++;
        end
        if (path_end !== want.path_end) begin
          $error("path_end: expected %0d, actual %0d", want.path_end, path_end);
          failures++;
        end
      end
    end
  end

  // Test sequence.
  initial begin
    wipe_mirror();
    path_ok = 1'b1;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // Slow receiver, mostly eager sender.
    send_gap_pct   = 19;
    recv_stall_pct = 75;
    test_directed();
    test_count_limits();
    test_random_traffic(370);

    // Slow sender, mostly eager receiver.
    send_gap_pct   = 75;
    recv_stall_pct = 19;
    test_random_traffic(370);
    test_output_backpressure();

    // Full rate on both sides.
    send_gap_pct   = 0;
    recv_stall_pct = 0;
    test_random_traffic(370);

    // Give any stray result time to show up before the verdict.
    wait_idle();
    repeat (TAIL_CYCLES) @(posedge clk);
    $display("Ran %0d transfers in, checked %0d results, set up %0d paths,",
             items_sent, results_checked, routes_allocated);
    $display("and cleared the table %0d times through the command.", clears_seen);
    if (failures == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  // Watchdog.
  initial begin
    #5_000_000;
    $display("Simulation FAILED");
    $finish;
  end

endmodule
